FILE: hw/rtl/ipat_pkg.sv
// Shared types and constants for the IP address text parser.
// Used by every module of the block; depends on nothing.
package ipat_pkg;

    // Character codes the parser recognizes.
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_F  = 8'h66;
    localparam logic [7:0] CH_UC_A  = 8'h41;
    localparam logic [7:0] CH_UC_F  = 8'h46;

    localparam int OCTET_MAX = 255;

    // Address family codes.
    localparam logic [1:0] FAM_V4 = 2'd0;
    localparam logic [1:0] FAM_V6 = 2'd1;

    // Result status codes.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_MALFORMED = 2'd1;
    localparam logic [1:0] ST_NOFAMILY  = 2'd2;

    typedef struct packed {
        logic [7:0] char_code;
        logic [1:0] family;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] addr_high;
        logic [63:0] addr_low;
    } t_out_item;

    // Address held as eight 16-bit groups, group 0 in the top bits.
    typedef logic [0:7][15:0] t_grps;

    // Dotted-quad subparser state.
    typedef struct packed {
        logic [7:0]      ov;     // octet value so far
        logic [1:0]      odc;    // digits in the current octet
        logic [1:0]      oidx;   // octets completed
        logic [0:2][7:0] qb;     // completed octets
        logic            qfail;
    } t_quad;

    typedef struct packed {
        logic        mid;        // inside a string
        logic [1:0]  fam;        // family latched on the first character
        logic        failed;
        t_quad       q;
        logic [15:0] gv;         // hex group value
        logic [2:0]  hdc;        // hex digits in the group
        t_grps       grp;        // address groups written so far
        logic [4:0]  bw;         // bytes written
        logic [4:0]  gap;        // byte position of the "::" gap
        logic        gap_seen;
        logic        lcp;        // leading colon must be followed by a colon
        logic        gcp;        // group colon must not end the string
        logic        emb;        // embedded dotted quad in progress
    } t_state;

endpackage

FILE: hw/rtl/ip_address_text_parser_unit.sv
// IPv4/IPv6 address text parser, one character per beat, NUL-terminated.
// Throughput: one character per cycle; the input register stalls only on a NUL
// beat while the previous result is still waiting in the result register.
// The result is registered; it becomes valid at the edge at which the NUL beat
// leaves the input register.
// Reset (synchronous, active low) empties both registers and clears all state.
module ip_address_text_parser_unit import ipat_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_item  i_item,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_item
);

    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      advance;
    logic      load;
    logic      out_free;
    t_state    cur;
    t_out_item res;

    // A non-NUL beat never produces a result and may always advance.
    assign advance = r_in_valid && (r_in_item.char_code != CH_NUL || out_free);
    assign load    = advance && r_in_item.char_code == CH_NUL;
    assign o_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_item <= i_item;
        end
    end

    ipat_parse u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_item  (r_in_item),
        .o_cur   (cur)
    );

    ipat_finish u_finish (
        .i_cur (cur),
        .o_res (res)
    );

    ipat_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (load),
        .i_res   (res),
        .o_free  (out_free),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_item  (o_item)
    );

`ifndef NO_ASSERTIONS
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |-> !(o_valid && !i_ready))
        else $error("result register overwritten before its beat was taken");

    a_fail_zero_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_item.status != ST_OK) |->
            (o_item.addr_high == 64'h0 && o_item.addr_low == 64'h0))
        else $error("failed conversion carries a nonzero address");
`endif

endmodule

FILE: hw/rtl/ipat_parse.sv
// Per-character parser state and its update for one accepted beat.
// Depends on ipat_pkg.
module ipat_parse import ipat_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_step,
    input  t_in_item i_item,
    output t_state   o_cur
);

    t_state r_st;
    t_state n_st;
    t_state cur;

    function automatic t_quad quad_feed(t_quad q, logic [7:0] c);
        t_quad       r;
        logic [11:0] v;
        r = q;
        v = {1'b0, q.ov, 3'b000} + {3'b000, q.ov, 1'b0} + {8'h00, c[3:0]};
        if (!q.qfail) begin
            if (c inside {[CH_ZERO:CH_NINE]}) begin
                if (v > 12'(OCTET_MAX) || q.odc == 2'd3) begin
                    r.qfail = 1'b1;
                end else begin
                    r.ov  = v[7:0];
                    r.odc = q.odc + 2'd1;
                end
            end else if (c == CH_DOT && q.odc != 2'd0 && q.oidx != 2'd3) begin
                r.qb[q.oidx] = q.ov;
                r.oidx       = q.oidx + 2'd1;
                r.ov         = 8'h00;
                r.odc        = 2'd0;
            end else begin
                r.qfail = 1'b1;
            end
        end
        return r;
    endfunction

    // Returns {is_hex, nibble}.
    function automatic logic [4:0] hex_of(logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c inside {[CH_ZERO:CH_NINE]}) begin
            r = {1'b1, c[3:0]};
        end else if (c inside {[CH_LC_A:CH_LC_F], [CH_UC_A:CH_UC_F]}) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

    function automatic t_state v6_feed(t_state s, logic [7:0] c);
        t_state     r;
        logic [4:0] h;
        logic       go;
        r  = s;
        go = 1'b1;
        h  = hex_of(c);
        if (s.emb) begin
            r.q = quad_feed(s.q, c);
        end else begin
            if (s.lcp) begin
                if (c != CH_COLON) begin
                    r.failed = 1'b1;
                    go       = 1'b0;
                end else begin
                    r.lcp = 1'b0;
                end
            end
            if (go) begin
                r.gcp = 1'b0;
                r.q   = quad_feed(s.q, c);
                if (h[4]) begin
                    if (s.hdc >= 3'd4) begin
                        r.failed = 1'b1;
                    end else begin
                        r.gv  = {s.gv[11:0], h[3:0]};
                        r.hdc = s.hdc + 3'd1;
                    end
                end else if (c == CH_COLON) begin
                    if (s.hdc == 3'd0) begin
                        if (s.gap_seen) begin
                            r.failed = 1'b1;
                        end else begin
                            r.gap_seen = 1'b1;
                            r.gap      = s.bw;
                            r.q        = '0;
                        end
                    end else if (s.bw > 5'd14) begin
                        r.failed = 1'b1;
                    end else begin
                        r.grp[s.bw[3:1]] = s.gv;
                        r.bw             = s.bw + 5'd2;
                        r.gv             = 16'h0000;
                        r.hdc            = 3'd0;
                        r.gcp            = 1'b1;
                        r.q              = '0;
                    end
                end else if (c == CH_DOT && s.hdc != 3'd0 && s.bw <= 5'd12) begin
                    r.emb = 1'b1;
                    r.gv  = 16'h0000;
                    r.hdc = 3'd0;
                end else begin
                    r.failed = 1'b1;
                end
            end
        end
        return r;
    endfunction

    // Between strings the state is all clear, so starting a string only
    // sets mid and latches the family.
    always_comb begin
        cur = r_st;
        if (!r_st.mid) begin
            cur.mid = 1'b1;
            cur.fam = i_item.family;
        end
    end

    always_comb begin
        n_st = cur;
        if (!r_st.mid && i_item.family == FAM_V6 && i_item.char_code == CH_COLON) begin
            n_st.lcp = 1'b1;
        end else if (i_item.char_code == CH_NUL) begin
            n_st = '0;
        end else if (!cur.failed) begin
            if (cur.fam == FAM_V4) begin
                n_st.q      = quad_feed(cur.q, i_item.char_code);
                n_st.failed = n_st.q.qfail;
            end else if (cur.fam == FAM_V6) begin
                n_st = v6_feed(cur, i_item.char_code);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= '0;
        end else if (i_step) begin
            r_st <= n_st;
        end
    end

    assign o_cur = cur;

`ifndef NO_ASSERTIONS
    a_nul_ends_string: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_item.char_code == CH_NUL) |=> !r_st.mid)
        else $error("string state survived its terminating beat");

    a_idle_state_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_st.mid |-> (r_st == '0))
        else $error("parser state not clear between strings");
`endif

endmodule

FILE: hw/rtl/ipat_finish.sv
// End-of-string evaluation: status, last group append and gap expansion.
// Purely combinational; depends on ipat_pkg.
module ipat_finish import ipat_pkg::*; (
    input  t_state    i_cur,
    output t_out_item o_res
);

    logic         qok;
    logic         ok4;
    logic         ok6;
    logic         bad_app;
    logic [4:0]   bw_a;
    t_grps        grp_a;
    t_grps        sh_g;
    t_grps        out_g;
    logic [127:0] shifted;
    logic [3:0]   shift_g;
    logic [3:0]   gap_g;

    assign qok = !i_cur.q.qfail && i_cur.q.odc != 2'd0 && i_cur.q.oidx == 2'd3;
    assign ok4 = !i_cur.failed && qok;

    // Append the pending group or embedded quad.
    always_comb begin
        grp_a   = i_cur.grp;
        bw_a    = i_cur.bw;
        bad_app = 1'b0;
        if (i_cur.emb) begin
            if (!qok || i_cur.bw > 5'd12) begin
                bad_app = 1'b1;
            end else begin
                grp_a[i_cur.bw[3:1]]        = {i_cur.q.qb[0], i_cur.q.qb[1]};
                grp_a[i_cur.bw[3:1] + 3'd1] = {i_cur.q.qb[2], i_cur.q.ov};
                bw_a                        = i_cur.bw + 5'd4;
            end
        end else if (i_cur.hdc != 3'd0) begin
            if (i_cur.bw > 5'd14) begin
                bad_app = 1'b1;
            end else begin
                grp_a[i_cur.bw[3:1]] = i_cur.gv;
                bw_a                 = i_cur.bw + 5'd2;
            end
        end
    end

    // Groups after the gap move to the end; the space opened is zero.
    assign shift_g = 4'd8 - {1'b0, bw_a[3:1]};
    assign gap_g   = i_cur.gap[4:1];
    assign shifted = grp_a >> {shift_g, 4'b0000};
    assign sh_g    = shifted;

    always_comb begin
        out_g = grp_a;
        if (i_cur.gap_seen) begin
            for (int k = 0; k < 8; k++) begin
                if (5'(k) < {1'b0, gap_g}) begin
                    out_g[k] = grp_a[k];
                end else if (5'(k) >= {1'b0, gap_g} + {1'b0, shift_g}) begin
                    out_g[k] = sh_g[k];
                end else begin
                    out_g[k] = 16'h0000;
                end
            end
        end
    end

    always_comb begin
        ok6 = 1'b0;
        if (!i_cur.failed && !i_cur.lcp && !i_cur.gcp && !bad_app) begin
            if (i_cur.gap_seen) begin
                ok6 = !(bw_a >= 5'd16 || i_cur.gap > bw_a);
            end else begin
                ok6 = (bw_a == 5'd16);
            end
        end
    end

    always_comb begin
        o_res = '0;
        if (i_cur.fam == FAM_V4) begin
            if (ok4) begin
                o_res.status   = ST_OK;
                o_res.addr_low = {32'h0, i_cur.q.qb[0], i_cur.q.qb[1],
                                  i_cur.q.qb[2], i_cur.q.ov};
            end else begin
                o_res.status = ST_MALFORMED;
            end
        end else if (i_cur.fam == FAM_V6) begin
            if (ok6) begin
                o_res.status    = ST_OK;
                o_res.addr_high = {out_g[0], out_g[1], out_g[2], out_g[3]};
                o_res.addr_low  = {out_g[4], out_g[5], out_g[6], out_g[7]};
            end else begin
                o_res.status = ST_MALFORMED;
            end
        end else begin
            o_res.status = ST_NOFAMILY;
        end
    end

endmodule

FILE: hw/rtl/ipat_out_reg.sv
// Result register with valid/ready handshake toward the consumer.
// Depends on ipat_pkg.
module ipat_out_reg import ipat_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_load,
    input  t_out_item i_res,
    output logic      o_free,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_item
);

    logic      r_valid;
    t_out_item r_item;

    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_free) begin
            r_item <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule
